[rtl/npt_pkg.sv]
// ----------------------------------------------------------------------------
// npt_pkg
// shared item layout and codes for the nearest point probe tracker
// ----------------------------------------------------------------------------
`default_nettype none

package npt_pkg;

   localparam int unsigned CoordW  = 32;
   localparam int unsigned DistW   = 64;
   localparam int unsigned IdxW    = 4;
   localparam int unsigned ActW    = 5;
   // cell numbers cover the largest supported chain of 64 cells
   localparam int unsigned CellIdW = 6;
   localparam int unsigned NumPos  = 3;
   localparam int unsigned NumVal  = 7;

   typedef enum logic [1:0] {
      KIND_LOAD   = 2'd0,
      KIND_SAMPLE = 2'd1,
      KIND_READ   = 2'd2,
      KIND_CLEAR  = 2'd3
   } kind_type;

   // one item as it travels down the chain; for a read the position,
   // value, distance and found fields collect the result
   typedef struct packed {
      kind_type                        kind;
      logic [IdxW-1:0]                 idx;
      logic [ActW-1:0]                 act;
      logic                            found;
      logic [DistW-1:0]                dist_sq;
      logic [NumPos-1:0][CoordW-1:0]   pos;
      logic [NumVal-1:0][CoordW-1:0]   val;
   } item_type;

endpackage

`default_nettype wire

[rtl/npt_cell.sv]
// ----------------------------------------------------------------------------
// npt_cell
// one probe of the chain: position, nearest record and a three stage pipe
// ----------------------------------------------------------------------------
`default_nettype none

module npt_cell
   import npt_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                advance,
   input  wire logic [CellIdW-1:0]  cell_id,
   input  wire logic                in_valid,
   input  wire item_type            in_item,
   output      logic                out_valid,
   output      item_type            out_item
);

   // probe position
   logic [NumPos-1:0][CoordW-1:0] pos_ff;

   // nearest record
   logic                          rec_valid_ff;
   logic [DistW-1:0]              rec_dist_ff;
   logic [NumPos-1:0][CoordW-1:0] rec_pos_ff;
   logic [NumVal-1:0][CoordW-1:0] rec_val_ff;

   // stage a: distance magnitudes
   logic                          a_valid_ff;
   item_type                      a_item_ff;
   logic [NumPos-1:0][CoordW-1:0] mag_ff;
   logic [NumPos-1:0][CoordW-1:0] mag_in;

   // stage b: squares
   logic                          b_valid_ff;
   item_type                      b_item_ff;
   logic [NumPos-1:0][DistW-1:0]  sq_ff;

   // stage c: compare and update
   logic                          c_valid_ff;
   item_type                      c_item_ff;
   item_type                      c_item_in;

   logic                          load_hit;
   logic                          read_hit;
   logic                          active;
   logic [DistW+1:0]              sum_wide;
   logic [DistW-1:0]              dist_sat;
   logic                          take;

   always_comb begin
      logic signed [CoordW:0] diff;
      for (int k = 0; k < NumPos; k++) begin
         diff = $signed({in_item.pos[k][CoordW-1], in_item.pos[k]})
              - $signed({pos_ff[k][CoordW-1], pos_ff[k]});
         if (diff[CoordW]) begin
            mag_in[k] = CoordW'(-diff);
         end else begin
            mag_in[k] = diff[CoordW-1:0];
         end
      end
   end

   assign load_hit = in_valid && (in_item.kind == KIND_LOAD)
                     && ({{(CellIdW-IdxW){1'b0}}, in_item.idx} == cell_id);

   assign read_hit = (b_item_ff.kind == KIND_READ)
                     && ({{(CellIdW-IdxW){1'b0}}, b_item_ff.idx} == cell_id);

   assign active = ({{(CellIdW-ActW){1'b0}}, b_item_ff.act} > cell_id);

   assign sum_wide = {2'b00, sq_ff[0]} + {2'b00, sq_ff[1]} + {2'b00, sq_ff[2]};
   assign dist_sat = (sum_wide[DistW+1:DistW] != 2'b00) ? {DistW{1'b1}}
                                                       : sum_wide[DistW-1:0];

   assign take = b_valid_ff && (b_item_ff.kind == KIND_SAMPLE) && active
                 && (!rec_valid_ff || (dist_sat < rec_dist_ff));

   always_comb begin
      c_item_in = b_item_ff;
      if (read_hit && rec_valid_ff) begin
         c_item_in.found   = 1'b1;
         c_item_in.dist_sq = rec_dist_ff;
         c_item_in.pos     = rec_pos_ff;
         c_item_in.val     = rec_val_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff   <= 1'b0;
         b_valid_ff   <= 1'b0;
         c_valid_ff   <= 1'b0;
         rec_valid_ff <= 1'b0;
      end else if (advance) begin
         a_valid_ff <= in_valid;
         b_valid_ff <= a_valid_ff;
         c_valid_ff <= b_valid_ff;
         if (b_valid_ff && (b_item_ff.kind == KIND_CLEAR)) begin
            rec_valid_ff <= 1'b0;
         end else if (take) begin
            rec_valid_ff <= 1'b1;
         end
      end
      if (advance) begin
         a_item_ff <= in_item;
         mag_ff    <= mag_in;
         b_item_ff <= a_item_ff;
         for (int k = 0; k < NumPos; k++) begin
            sq_ff[k] <= DistW'(mag_ff[k]) * DistW'(mag_ff[k]);
         end
         c_item_ff <= c_item_in;
         if (load_hit) begin
            pos_ff <= in_item.pos;
         end
         if (take) begin
            rec_dist_ff <= dist_sat;
            rec_pos_ff  <= b_item_ff.pos;
            rec_val_ff  <= b_item_ff.val;
         end
      end
   end

   assign out_valid = c_valid_ff;
   assign out_item  = c_item_ff;

endmodule

`default_nettype wire

[rtl/nearest_point_probe_tracker.sv]
// ----------------------------------------------------------------------------
// nearest_point_probe_tracker
// tracks, for each probe point, the nearest sample offered so far
// ----------------------------------------------------------------------------
//
//   channel   prefix   direction   moves
//   request   req_     in          load, sample, read or clear item
//   response  rsp_     out         probe record, one per read item
//   control   csr_     in          active_probes register write
//
// one item enters per cycle unless the chain is stopped; it walks a
// chain of MAX_PROBES cells, three stages each, and a read then lands
// in the response register; each cell pipes abs difference, square, compare
// synchronous reset clears all records, the pipe and active_probes
// the chain stops only when a read reaches the end while the response
// register still holds an item that has not been taken
// ----------------------------------------------------------------------------
`default_nettype none

module nearest_point_probe_tracker
   import npt_pkg::*;
#(
   parameter int unsigned MAX_PROBES = 16
)
(
   input  wire logic                clock,
   input  wire logic                reset,

   input  wire logic                csr_valid,
   output      logic                csr_ready,
   input  wire logic [ActW-1:0]     csr_active_probes,

   input  wire logic                req_valid,
   output      logic                req_ready,
   input  wire logic [1:0]          req_kind,
   input  wire logic [IdxW-1:0]     req_probe_index,
   input  wire logic [31:0]         req_coord_x,
   input  wire logic [31:0]         req_coord_y,
   input  wire logic [31:0]         req_coord_z,
   input  wire logic [31:0]         req_density,
   input  wire logic [31:0]         req_pressure,
   input  wire logic [31:0]         req_temperature,
   input  wire logic [31:0]         req_enthalpy,
   input  wire logic [31:0]         req_vel_x,
   input  wire logic [31:0]         req_vel_y,
   input  wire logic [31:0]         req_vel_z,

   output      logic                rsp_valid,
   input  wire logic                rsp_ready,
   output      logic                rsp_found,
   output      logic [63:0]         rsp_dist_sq,
   output      logic [31:0]         rsp_near_x,
   output      logic [31:0]         rsp_near_y,
   output      logic [31:0]         rsp_near_z,
   output      logic [31:0]         rsp_out_density,
   output      logic [31:0]         rsp_out_pressure,
   output      logic [31:0]         rsp_out_temperature,
   output      logic [31:0]         rsp_out_enthalpy,
   output      logic [31:0]         rsp_out_vel_x,
   output      logic [31:0]         rsp_out_vel_y,
   output      logic [31:0]         rsp_out_vel_z
);

   // active probe count register
   logic [ActW-1:0]     active_ff;

   // chain taps: entry at 0, exit at MAX_PROBES
   logic [MAX_PROBES:0] chain_valid;
   item_type            chain_item [MAX_PROBES+1];
   item_type            entry_item;

   // response register
   logic                rsp_valid_ff;
   item_type            rsp_item_ff;

   logic                advance;
   logic                exit_read;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= '0;
      end else if (csr_valid) begin
         active_ff <= csr_active_probes;
      end
   end

   // build the entry item; the active count rides along with it, and a
   // read starts with an all-zero record that the addressed cell fills if it has one
   always_comb begin
      entry_item       = '0;
      entry_item.kind  = kind_type'(req_kind);
      entry_item.idx   = req_probe_index;
      entry_item.act   = active_ff;
      if (kind_type'(req_kind) != KIND_READ) begin
         entry_item.pos = {req_coord_z, req_coord_y, req_coord_x};
         entry_item.val = {req_vel_z, req_vel_y, req_vel_x, req_enthalpy,
                           req_temperature, req_pressure, req_density};
      end
   end

   // only a read leaving the chain needs the response register
   assign exit_read = chain_valid[MAX_PROBES]
                      && (chain_item[MAX_PROBES].kind == KIND_READ);
   assign advance   = !(exit_read && rsp_valid_ff && !rsp_ready);
   assign req_ready = advance;

   assign chain_valid[0] = req_valid;
   assign chain_item[0]  = entry_item;

   for (genvar i = 0; i < MAX_PROBES; i++) begin : g_cell
      npt_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .advance   (advance),
         .cell_id   (CellIdW'(i)),
         .in_valid  (chain_valid[i]),
         .in_item   (chain_item[i]),
         .out_valid (chain_valid[i+1]),
         .out_item  (chain_item[i+1])
      );
   end

   // response register; loads, sample and clear items simply drop off
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance && exit_read) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (advance && exit_read) begin
         rsp_item_ff <= chain_item[MAX_PROBES];
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_found           = rsp_item_ff.found;
   assign rsp_dist_sq         = rsp_item_ff.dist_sq;
   assign rsp_near_x          = rsp_item_ff.pos[0];
   assign rsp_near_y          = rsp_item_ff.pos[1];
   assign rsp_near_z          = rsp_item_ff.pos[2];
   assign rsp_out_density     = rsp_item_ff.val[0];
   assign rsp_out_pressure    = rsp_item_ff.val[1];
   assign rsp_out_temperature = rsp_item_ff.val[2];
   assign rsp_out_enthalpy    = rsp_item_ff.val[3];
   assign rsp_out_vel_x       = rsp_item_ff.val[4];
   assign rsp_out_vel_y       = rsp_item_ff.val[5];
   assign rsp_out_vel_z       = rsp_item_ff.val[6];

endmodule

`default_nettype wire
